@@ rtl/usv_pkg.sv @@
package usv_pkg;

    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } usv_in_t;

    typedef struct packed {
        logic error_seen;
        logic string_done;
        logic string_valid;
    } usv_out_t;

    // byte as seen when no sequence is open, plus its continuation bounds
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
        logic       lead_bad;
        logic [1:0] need;
        logic [7:0] lo;
        logic [7:0] hi;
    } usv_item_t;

endpackage

@@ rtl/utf8_stream_validator.sv @@
// utf8_stream_validator: checks byte strings for well-formed utf-8.
// input channel s_valid/s_ready/s_data carries one transaction per byte:
// data_byte, byte_present (0 for an empty closing transaction) and last,
// which marks the end of a string.
// result channel m_valid/m_ready/m_data returns exactly one transaction per
// input transaction, in order: error_seen (sticky error of the current
// string), string_done (copy of last) and string_valid (verdict on the
// closing transaction, 0 otherwise).
// a byte passes a queue entry and the output register before its result is
// valid; throughput is one byte per cycle unless the receiver stalls.
// a front end classifies each byte as it is accepted and writes it into a
// two-entry queue; the back end checks it against the open sequence and
// loads the output register.
// when the receiver stalls, the output register holds its result, the queue
// fills, and s_ready drops once it holds two transactions.
// reset (aresetn low, synchronous) empties the queue and output register and
// returns the sequence state to the start of a string.
module utf8_stream_validator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  usv_pkg::usv_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output usv_pkg::usv_out_t  m_data
);
    import usv_pkg::*;

    logic      push_valid, push_ready;
    usv_item_t push_item;
    logic      pop_valid, pop_ready;
    usv_item_t pop_item;

    usv_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    usv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    usv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ rtl/usv_front.sv @@
module usv_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  usv_pkg::usv_in_t    s_data,
    output logic                push_valid,
    input  logic                push_ready,
    output usv_pkg::usv_item_t  push_item
);
    import usv_pkg::*;

    logic [7:0] b;

    assign b          = s_data.data_byte;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_item              = '0;
        push_item.data_byte    = b;
        push_item.byte_present = s_data.byte_present;
        push_item.last         = s_data.last;
        push_item.lo           = CONT_LO;
        push_item.hi           = CONT_HI;
        push_item.need         = 2'd0;
        push_item.lead_bad     = 1'b0;
        if (b[7] == 1'b0) begin
            push_item.need = 2'd0;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            push_item.need = 2'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            push_item.need = 2'd2;
            if (b == LEAD_E0) begin
                push_item.lo = E0_LO;
            end
            if (b == LEAD_ED) begin
                push_item.hi = ED_HI;
            end
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            push_item.need = 2'd3;
            if (b == LEAD_F0) begin
                push_item.lo = F0_LO;
            end
            if (b == LEAD_F4) begin
                push_item.hi = F4_HI;
            end
        end else begin
            // stray continuation, overlong C0/C1 or F5-FF
            push_item.lead_bad = 1'b1;
        end
    end

endmodule

@@ rtl/usv_queue.sv @@
module usv_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  usv_pkg::usv_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output usv_pkg::usv_item_t  pop_item
);
    import usv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    usv_item_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

@@ rtl/usv_back.sv @@
module usv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  usv_pkg::usv_item_t  pop_item,
    output logic                m_valid,
    input  logic                m_ready,
    output usv_pkg::usv_out_t   m_data
);
    import usv_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic [7:0] lo_reg, lo_next;
    logic [7:0] hi_reg, hi_next;
    logic       failed_reg, failed_next;
    logic       m_valid_reg, m_valid_next;
    usv_out_t   m_data_reg, m_data_next;
    logic       take;
    logic [1:0] pend_upd;
    logic [7:0] lo_upd, hi_upd;
    logic       failed_upd;

    assign pop_ready = !m_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // sequence check for the byte at the head of the queue
    always_comb begin
        pend_upd   = pend_reg;
        lo_upd     = lo_reg;
        hi_upd     = hi_reg;
        failed_upd = failed_reg;
        if (pop_item.byte_present && !failed_reg) begin
            if (pend_reg == 2'd0) begin
                if (pop_item.lead_bad) begin
                    failed_upd = 1'b1;
                end else if (pop_item.need != 2'd0) begin
                    pend_upd = pop_item.need;
                    lo_upd   = pop_item.lo;
                    hi_upd   = pop_item.hi;
                end
            end else begin
                if (pop_item.data_byte < lo_reg || pop_item.data_byte > hi_reg) begin
                    failed_upd = 1'b1;
                    pend_upd   = 2'd0;
                end else begin
                    pend_upd = pend_reg - 2'd1;
                end
                lo_upd = CONT_LO;
                hi_upd = CONT_HI;
            end
        end
    end

    always_comb begin
        pend_next    = pend_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        failed_next  = failed_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (take) begin
            m_valid_next             = 1'b1;
            m_data_next.error_seen   = failed_upd;
            m_data_next.string_done  = pop_item.last;
            m_data_next.string_valid = pop_item.last && !failed_upd && (pend_upd == 2'd0);
            if (pop_item.last) begin
                pend_next   = 2'd0;
                lo_next     = CONT_LO;
                hi_next     = CONT_HI;
                failed_next = 1'b0;
            end else begin
                pend_next   = pend_upd;
                lo_next     = lo_upd;
                hi_next     = hi_upd;
                failed_next = failed_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 2'd0;
            lo_reg      <= CONT_LO;
            hi_reg      <= CONT_HI;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    a_valid_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.string_valid) |->
            (m_data_reg.string_done && !m_data_reg.error_seen))
        else $error("string_valid without string_done or with error");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && pop_item.last) |=> (pend_reg == 2'd0 && !failed_reg))
        else $error("state not cleared after closing transaction");

    a_bounds_need_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (lo_reg != CONT_LO || hi_reg != CONT_HI) |-> (pend_reg != 2'd0))
        else $error("narrowed bounds with no continuation owed");

    a_failed_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> (pend_reg == 2'd0))
        else $error("continuations owed after an error");

endmodule
